[design/bpc_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bpc_pkg
// shared types, widths and register codes of the box plane culling block
// ---------------------------------------------------------------------------
package bpc_pkg;

  localparam int MAX_PLANES      = 6;
  localparam int CORNERS_PER_BOX = 8;
  localparam int CORNER_IDX_W    = $clog2(CORNERS_PER_BOX);

  localparam int DEPTH_W  = 24;  // Q16.8 coordinate
  localparam int NORM_W   = 11;  // Q1.10 normal component
  localparam int OFF_W    = 28;  // Q20.8 plane offset
  localparam int OFF_SHIFT = 10; // offset to 18 fraction bits
  localparam int PROD_W   = DEPTH_W + NORM_W;
  localparam int DOT_W    = OFF_W + OFF_SHIFT;  // holds the sum of three products too
  localparam int ACTIVE_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PLANES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_ZERO    = 3'd1;

  typedef logic signed [DEPTH_W-1:0] depth_t;

  typedef struct packed {
    logic [CFG_DATA_W-OFF_W-3*NORM_W-1:0] spare;
    logic signed [OFF_W-1:0]  offset;
    logic signed [NORM_W-1:0] nz;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nx;
  } plane_t;

  typedef struct packed {
    depth_t x;
    depth_t y;
    depth_t z;
    logic   clear;
  } corner_t;

  // top to fold: one corner moves into the box state
  typedef struct packed {
    logic   fire;
    logic   clear;
    depth_t z;
  } fold_in_t;

  // fold to top
  typedef struct packed {
    logic last;
    logic out_valid;
  } fold_stat_t;

endpackage
`default_nettype wire

[design/bpc_intf.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bpc channel interfaces
// corner input, result output and register write channels
// ---------------------------------------------------------------------------
interface bpc_corner_if;
  logic            valid;
  logic            ready;
  bpc_pkg::depth_t corner_x;
  bpc_pkg::depth_t corner_y;
  bpc_pkg::depth_t corner_z;
  logic            clear_bounds;

  modport source (output valid, corner_x, corner_y, corner_z, clear_bounds, input ready);
  modport sink (input valid, corner_x, corner_y, corner_z, clear_bounds, output ready);
endinterface

interface bpc_result_if;
  logic            valid;
  logic            ready;
  logic            visible;
  bpc_pkg::depth_t near_z;
  bpc_pkg::depth_t far_z;

  modport source (output valid, visible, near_z, far_z, input ready);
  modport sink (input valid, visible, near_z, far_z, output ready);
endinterface

interface bpc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bpc_pkg::CFG_IDX_W-1:0]      index;
  logic [bpc_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/bpc_cfg_regs.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bpc_cfg_regs
// plane count and packed plane registers, written through the cfg channel
// ---------------------------------------------------------------------------
module bpc_cfg_regs (
  input  wire                                clk,
  input  wire                                rst,
  bpc_cfg_if.sink                            cfg,
  output logic [bpc_pkg::ACTIVE_W-1:0]       active_planes,
  output bpc_pkg::plane_t [bpc_pkg::MAX_PLANES-1:0] planes
);
  import bpc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_planes <= '0;
      planes        <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == REG_ACTIVE_PLANES) begin
        active_planes <= cfg.data[ACTIVE_W-1:0];
      end
      for (int p = 0; p < MAX_PLANES; p++) begin
        if (cfg.index == REG_PLANE_ZERO + CFG_IDX_W'(p)) begin
          planes[p] <= plane_t'(cfg.data);
        end
      end
    end
  end

endmodule
`default_nettype wire

[design/bpc_plane_test.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bpc_plane_test
// exact half-space test of one corner against one plane
// ---------------------------------------------------------------------------
module bpc_plane_test (
  input  bpc_pkg::corner_t corner,
  input  bpc_pkg::plane_t  plane,
  output logic             hit
);
  import bpc_pkg::*;

  logic signed [NORM_W-1:0] nx, ny, nz;
  logic signed [PROD_W-1:0] px, py, pz;
  logic signed [DOT_W-1:0]  dot;
  logic signed [DOT_W-1:0]  thresh;

  assign nx = plane.nx;
  assign ny = plane.ny;
  assign nz = plane.nz;

  assign px = PROD_W'(corner.x) * PROD_W'(nx);
  assign py = PROD_W'(corner.y) * PROD_W'(ny);
  assign pz = PROD_W'(corner.z) * PROD_W'(nz);

  // all terms carry 18 fraction bits
  assign dot    = DOT_W'(px) + DOT_W'(py) + DOT_W'(pz);
  assign thresh = $signed({plane.offset, {OFF_SHIFT{1'b0}}});
  assign hit    = (dot >= thresh);

endmodule
`default_nettype wire

[design/bpc_box_fold.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bpc_box_fold
// per-box plane coverage and depth range, running bounds and result register
// ---------------------------------------------------------------------------
module bpc_box_fold (
  input  wire                              clk,
  input  wire                              rst,
  input  bpc_pkg::fold_in_t                fin,
  input  logic [bpc_pkg::MAX_PLANES-1:0]   plane_hit,
  input  logic [bpc_pkg::ACTIVE_W-1:0]     active_planes,
  output bpc_pkg::fold_stat_t              stat,
  bpc_result_if.source                     result
);
  import bpc_pkg::*;

  logic [CORNER_IDX_W-1:0] corner_index;
  logic [MAX_PLANES-1:0]   inside_seen;
  depth_t                  box_min;
  depth_t                  box_max;
  depth_t                  running_near;
  depth_t                  running_far;
  logic                    clear_pending;

  logic                    out_valid;
  logic                    out_visible;
  depth_t                  out_near;
  depth_t                  out_far;

  logic                    last;
  logic [MAX_PLANES-1:0]   seen_next;
  depth_t                  box_min_next;
  depth_t                  box_max_next;
  logic                    clear_next;
  logic [ACTIVE_W-1:0]     plane_count;
  logic [MAX_PLANES-1:0]   need;
  logic                    vis;
  depth_t                  base_near;
  depth_t                  base_far;
  depth_t                  near_next;
  depth_t                  far_next;

  assign last = (corner_index == CORNER_IDX_W'(CORNERS_PER_BOX - 1));

  always_comb begin
    seen_next    = inside_seen | plane_hit;
    box_min_next = (fin.z < box_min) ? fin.z : box_min;
    box_max_next = (fin.z > box_max) ? fin.z : box_max;
    clear_next   = clear_pending | fin.clear;

    plane_count = (active_planes > ACTIVE_W'(MAX_PLANES)) ? ACTIVE_W'(MAX_PLANES)
                                                          : active_planes;
    for (int p = 0; p < MAX_PLANES; p++) begin
      need[p] = (ACTIVE_W'(p) < plane_count);
    end
    vis = ((seen_next & need) == need);

    base_near = clear_next ? DEPTH_MAX : running_near;
    base_far  = clear_next ? DEPTH_MIN : running_far;
    near_next = (vis && (box_min_next < base_near)) ? box_min_next : base_near;
    far_next  = (vis && (box_max_next > base_far)) ? box_max_next : base_far;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_index  <= '0;
      inside_seen   <= '0;
      box_min       <= DEPTH_MAX;
      box_max       <= DEPTH_MIN;
      running_near  <= DEPTH_MAX;
      running_far   <= DEPTH_MIN;
      clear_pending <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (fin.fire && last) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (fin.fire) begin
        if (last) begin
          corner_index  <= '0;
          inside_seen   <= '0;
          box_min       <= DEPTH_MAX;
          box_max       <= DEPTH_MIN;
          clear_pending <= 1'b0;
          running_near  <= near_next;
          running_far   <= far_next;
        end else begin
          corner_index  <= corner_index + 1'b1;
          inside_seen   <= seen_next;
          box_min       <= box_min_next;
          box_max       <= box_max_next;
          clear_pending <= clear_next;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fin.fire && last) begin
      out_visible <= vis;
      out_near    <= near_next;
      out_far     <= far_next;
    end
  end

  assign result.valid   = out_valid;
  assign result.visible = out_visible;
  assign result.near_z  = out_near;
  assign result.far_z   = out_far;

  assign stat.last      = last;
  assign stat.out_valid = out_valid;

endmodule
`default_nettype wire

[design/box_plane_cull_depth_bounds.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// box_plane_cull_depth_bounds
// culls a box, given as eight corner words, against up to six clip planes
// and keeps running near and far depth bounds of the boxes that survive
// ---------------------------------------------------------------------------
// The block takes one corner word per cycle. A corner word is registered on
// acceptance; from that register all six plane tests (three 24x11 products, a
// sum and a compare each) run side by side and fold into the box state. The
// eighth corner of a box writes one result word into the output register when
// it leaves the input register. Sustained rate is one corner per cycle and
// one result per eight corners; the input stalls only when an eighth corner
// finds the output register still full.
// Registers: index 0 is the plane count (values above six act as six,
// zero makes every box visible), indexes 1 to 6 hold the packed planes
// (nx, ny, nz Q1.10 in bits 32:0, offset Q20.8 in bits 60:33). Write them
// only while no box is in flight. A clear_bounds flag on any corner restarts
// the running bounds at the end of that box, culled or not.
// ---------------------------------------------------------------------------
module box_plane_cull_depth_bounds (
  input  wire          clk,
  input  wire          rst,
  bpc_corner_if.sink   corner,
  bpc_result_if.source result,
  bpc_cfg_if.sink      cfg
);
  import bpc_pkg::*;

  // register file
  logic [ACTIVE_W-1:0]       active_planes;
  plane_t [MAX_PLANES-1:0]   planes;

  bpc_cfg_regs u_cfg_regs (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .active_planes (active_planes),
    .planes        (planes)
  );

  // input register
  logic       in_valid;
  corner_t    in_word;
  fold_stat_t stat;
  fold_in_t   fin;
  logic       fire;

  // a non-final corner never waits; the final one waits for a free output slot
  assign fire         = in_valid && (!stat.last || !stat.out_valid || result.ready);
  assign corner.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (corner.ready) begin
      in_valid <= corner.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (corner.ready && corner.valid) begin
      in_word.x     <= corner.corner_x;
      in_word.y     <= corner.corner_y;
      in_word.z     <= corner.corner_z;
      in_word.clear <= corner.clear_bounds;
    end
  end

  // plane tests, all in parallel
  logic [MAX_PLANES-1:0] plane_hit;

  for (genvar p = 0; p < MAX_PLANES; p++) begin : g_plane
    bpc_plane_test u_plane_test (
      .corner (in_word),
      .plane  (planes[p]),
      .hit    (plane_hit[p])
    );
  end

  // box fold and result register
  assign fin.fire  = fire;
  assign fin.clear = in_word.clear;
  assign fin.z     = in_word.z;

  bpc_box_fold u_box_fold (
    .clk           (clk),
    .rst           (rst),
    .fin           (fin),
    .plane_hit     (plane_hit),
    .active_planes (active_planes),
    .stat          (stat),
    .result        (result)
  );

endmodule
`default_nettype wire

[design/bpc_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// bpc_checker
// port-level checks of the box culling block, bound to the top level
// ---------------------------------------------------------------------------
module bpc_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  corner_valid,
  input wire                  corner_ready,
  input wire                  result_valid,
  input wire                  result_ready,
  input wire                  visible,
  input bpc_pkg::depth_t      near_z,
  input bpc_pkg::depth_t      far_z
);
  import bpc_pkg::*;

  logic [CORNER_IDX_W-1:0] corner_count;
  logic [1:0]              pending;
  logic                    box_done;
  logic                    word_out;

  assign box_done = corner_valid && corner_ready
                    && (corner_count == CORNER_IDX_W'(CORNERS_PER_BOX - 1));
  assign word_out = result_valid && result_ready;

  // boxes accepted whose result is not yet taken
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= '0;
      pending      <= '0;
    end else begin
      if (corner_valid && corner_ready) begin
        corner_count <= corner_count + 1'b1;
      end
      pending <= pending + {1'b0, box_done} - {1'b0, word_out};
    end
  end

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (pending != 2'd0))
    else $error("result word without a completed box");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more boxes in flight than the block can hold");

  a_visible_order: assert property (@(posedge clk) disable iff (rst)
    (result_valid && visible) |-> (near_z <= far_z))
    else $error("visible box with near bound above far bound");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(visible) && $stable(near_z) && $stable(far_z)))
    else $error("stalled result word changed");

endmodule

bind box_plane_cull_depth_bounds bpc_checker u_bpc_checker (
  .clk          (clk),
  .rst          (rst),
  .corner_valid (corner.valid),
  .corner_ready (corner.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .visible      (result.visible),
  .near_z       (result.near_z),
  .far_z        (result.far_z)
);
`default_nettype wire

[verif/tb_box_plane_cull_depth_bounds.sv]
// ---------------------------------------------------------------------------
// tb_box_plane_cull_depth_bounds
// self-checking bench for the box plane culling block: boxes of eight corner
// words go in, one result word per box comes out and is compared with an
// in-bench model of the plane tests and the running depth bounds
// ---------------------------------------------------------------------------
module tb_box_plane_cull_depth_bounds;
  import bpc_pkg::*;

  // one result word as the bench predicts it
  typedef struct packed {
    logic   visible;
    depth_t near_z;
    depth_t far_z;
  } box_result_t;

  // one row of the directed table: a corner word and, on the eighth corner
  // of a box whose answer is plain to see, the result typed in by hand
  typedef struct packed {
    depth_t x;
    depth_t y;
    depth_t z;
    logic   clear;
    logic   typed;
    logic   visible;
    depth_t near_z;
    depth_t far_z;
  } directed_row_t;

  localparam int CLK_PERIOD        = 10;
  localparam int RESET_CYCLES      = 12;
  localparam int SETTLE_CYCLES     = 6;   // result is registered as the last corner leaves the input register
  localparam int SEGMENTS          = 12;
  localparam int BOXES_PER_SEGMENT = 5;
  localparam int WATCHDOG_TIME     = 2_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = REG_PLANE_ZERO + CFG_IDX_W'(MAX_PLANES);
  localparam logic [ACTIVE_W-1:0]  ALL_PLANES_SATURATED = '1;

  // plane whose offset no corner can reach: every box is culled by it
  localparam plane_t UNREACHABLE_PLANE = '{
    spare: '0, offset: {1'b0, {(OFF_W-1){1'b1}}}, nz: '0, ny: '0, nx: 11'sd1
  };

  localparam logic [NORM_W-1:0] NORM_EDGES [4] = '{11'h400, 11'h3FF, 11'h000, 11'h7FF};
  localparam logic [OFF_W-1:0]  OFF_EDGES [4] =
    '{28'h8000000, 28'h7FFFFFF, 28'h0000000, 28'hFFFFFFF};

  localparam int DIRECTED_ROWS = 24;
  localparam int CULL_ROW      = 16;  // box three runs against the unreachable plane

  localparam directed_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
    // box one: no planes after reset, so visible; corners hit every coordinate
    // extreme and the bounds open to the full depth range
    '{DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, 1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{DEPTH_MIN, DEPTH_MIN, DEPTH_MIN, 1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{DEPTH_MAX, DEPTH_MIN, 24'sd0,    1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{DEPTH_MIN, DEPTH_MAX, -24'sd1,   1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{24'sd0,    24'sd0,    24'sd1,    1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{-24'sd1,   -24'sd1,   24'sd256,  1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{DEPTH_MAX, 24'sd0,    DEPTH_MIN, 1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{24'sd0,    DEPTH_MIN, DEPTH_MAX, 1'b0, 1'b1, 1'b1, DEPTH_MIN, DEPTH_MAX},
    // box two: clear mid-box, every depth zero, so both bounds collapse to zero
    '{24'sd1,    -24'sd1,   24'sd0,    1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{DEPTH_MAX, DEPTH_MAX, 24'sd0,    1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{DEPTH_MIN, DEPTH_MIN, 24'sd0,    1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{-24'sd256, 24'sd256,  24'sd0,    1'b1, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{24'sd0,    24'sd0,    24'sd0,    1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{24'sd1234, -24'sd5678, 24'sd0,   1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{DEPTH_MIN, DEPTH_MAX, 24'sd0,    1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{DEPTH_MAX, DEPTH_MIN, 24'sd0,    1'b0, 1'b1, 1'b1, 24'sd0, 24'sd0},
    // box three: plane count seven acts as six, plane zero is out of reach,
    // so the box is culled; its clear still resets the bounds
    '{DEPTH_MAX, 24'sd0,    DEPTH_MAX, 1'b1, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{DEPTH_MAX, DEPTH_MAX, DEPTH_MIN, 1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{DEPTH_MIN, DEPTH_MIN, 24'sd512,  1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{24'sd0,    24'sd0,    24'sd0,    1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{24'sd1,    24'sd1,    -24'sd512, 1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{-24'sd1,   DEPTH_MAX, 24'sd77,   1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{24'sd4096, DEPTH_MIN, -24'sd77,  1'b0, 1'b0, 1'b0, 24'sd0, 24'sd0},
    '{DEPTH_MAX, -24'sd4096, 24'sd3,   1'b0, 1'b1, 1'b0, DEPTH_MAX, DEPTH_MIN}
  };

  logic clk;
  logic rst;

  bpc_corner_if corner_ch ();
  bpc_result_if result_ch ();
  bpc_cfg_if    cfg_ch ();

  box_plane_cull_depth_bounds uut (
    .clk   (clk),
    .rst   (rst),
    .corner(corner_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  // idle odds in percent, changed between phases
  int unsigned send_idle_pct;
  int unsigned result_stall_pct;
  int unsigned mismatches;

  // bench copy of the register file
  logic [ACTIVE_W-1:0] plane_count_cfg;
  plane_t              plane_regs [MAX_PLANES];

  // bench copy of the box and bound state
  int unsigned           box_corner_cnt;
  logic [MAX_PLANES-1:0] planes_hit;
  depth_t                box_lo;
  depth_t                box_hi;
  depth_t                bound_near;
  depth_t                bound_far;
  logic                  clear_req;

  // results still owed by the block, oldest first
  box_result_t box_verdicts [$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ------------------------------------------------------------------------
  // model of the block
  // ------------------------------------------------------------------------

  function automatic void reset_model();
    plane_count_cfg = '0;
    foreach (plane_regs[p]) plane_regs[p] = '0;
    box_corner_cnt = 0;
    planes_hit     = '0;
    box_lo         = DEPTH_MAX;
    box_hi         = DEPTH_MIN;
    bound_near     = DEPTH_MAX;
    bound_far      = DEPTH_MIN;
    clear_req      = 1'b0;
  endfunction

  // folds one accepted corner word into the box; returns 1 with the result
  // word when the corner closes a box
  function automatic logic fold_corner(input corner_t c, output box_result_t res);
    longint                dot;
    longint                limit;
    int unsigned           count;
    logic [MAX_PLANES-1:0] need;
    logic                  keep;
    res = '0;
    // exact test: 18 fraction bits on both sides, no rounding
    for (int p = 0; p < MAX_PLANES; p++) begin
      dot = longint'(c.x) * longint'($signed(plane_regs[p].nx))
          + longint'(c.y) * longint'($signed(plane_regs[p].ny))
          + longint'(c.z) * longint'($signed(plane_regs[p].nz));
      limit = longint'($signed(plane_regs[p].offset)) * 1024;
      if (dot >= limit) planes_hit[p] = 1'b1;
    end
    if (c.z < box_lo) box_lo = c.z;
    if (c.z > box_hi) box_hi = c.z;
    if (c.clear) clear_req = 1'b1;
    if (box_corner_cnt < CORNERS_PER_BOX - 1) begin
      box_corner_cnt++;
      return 1'b0;
    end
    // plane count above six acts as six, zero means no plane can cull
    count = (plane_count_cfg > MAX_PLANES) ? MAX_PLANES : plane_count_cfg;
    need  = MAX_PLANES'((7'd1 << count) - 7'd1);
    keep  = ((planes_hit & need) == need);
    // clear applies to culled boxes too
    if (clear_req) begin
      bound_near = DEPTH_MAX;
      bound_far  = DEPTH_MIN;
    end
    if (keep) begin
      if (box_lo < bound_near) bound_near = box_lo;
      if (box_hi > bound_far) bound_far = box_hi;
    end
    res.visible = keep;
    res.near_z  = bound_near;
    res.far_z   = bound_far;
    box_corner_cnt = 0;
    planes_hit     = '0;
    box_lo         = DEPTH_MAX;
    box_hi         = DEPTH_MIN;
    clear_req      = 1'b0;
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------------
  // drivers, all called at a falling edge and returning at one
  // ------------------------------------------------------------------------

  // one corner word: random idle first, then hold valid until accepted
  task automatic send_corner(input corner_t c, input logic typed,
                             input box_result_t typed_res);
    box_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      corner_ch.valid = 1'b0;
      @(negedge clk);
    end
    corner_ch.valid        = 1'b1;
    corner_ch.corner_x     = c.x;
    corner_ch.corner_y     = c.y;
    corner_ch.corner_z     = c.z;
    corner_ch.clear_bounds = c.clear;
    @(posedge clk);
    while (!corner_ch.ready) @(posedge clk);
    if (fold_corner(c, predicted)) box_verdicts.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // register write; valid stays up for back-to-back writes, caller lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    int slot;
    slot = int'(idx) - int'(REG_PLANE_ZERO);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_ACTIVE_PLANES) plane_count_cfg = value[ACTIVE_W-1:0];
    else if (slot >= 0 && slot < MAX_PLANES) plane_regs[slot] = value;
    @(negedge clk);
  endtask

  // wait until every owed result is back, then let the pipe settle
  task automatic drain();
    while (box_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // random plane: most often offsets in the range of real dot products, some
  // fully random words and some edge values
  function automatic plane_t make_plane();
    plane_t pl;
    int     off_near;
    pl = {$urandom, $urandom};
    off_near = int'($urandom_range(0, 67108863)) - 33554432;
    case ($urandom_range(4))
      0: ;
      1, 2: pl.offset = off_near[OFF_W-1:0];
      3: begin
        pl.nx     = NORM_EDGES[$urandom_range(3)];
        pl.ny     = NORM_EDGES[$urandom_range(3)];
        pl.nz     = NORM_EDGES[$urandom_range(3)];
        pl.offset = OFF_EDGES[$urandom_range(3)];
      end
      default: pl = $urandom_range(1) ? '1 : '0;
    endcase
    return pl;
  endfunction

  // new register set for a phase; upper bits of the count word are junk
  task automatic load_planes(input logic [ACTIVE_W-1:0] count);
    write_reg(REG_ACTIVE_PLANES, {$urandom, 29'($urandom_range(0, 536870911)), count});
    for (int p = 0; p < MAX_PLANES; p++) begin
      write_reg(REG_PLANE_ZERO + CFG_IDX_W'(p), make_plane());
    end
    // unmapped index must leave everything alone
    if ($urandom_range(2) == 0) write_reg(REG_UNMAPPED, {$urandom, $urandom});
    cfg_ch.valid = 1'b0;
  endtask

  function automatic depth_t jitter(input int bits);
    return depth_t'($urandom_range(0, (1 << bits) - 1)) - depth_t'(1 << (bits - 1));
  endfunction

  // one box: mostly corners clustered round a center, so plane tests split
  // and boxes get culled; now and then eight unrelated corners
  task automatic send_random_box();
    corner_t c;
    depth_t  cx;
    depth_t  cy;
    depth_t  cz;
    int      spread;
    logic    scattered;
    scattered = ($urandom_range(3) == 0);
    spread    = $urandom_range(1, 16);
    cx = depth_t'($urandom);
    cy = depth_t'($urandom);
    cz = depth_t'($urandom);
    for (int k = 0; k < CORNERS_PER_BOX; k++) begin
      if (scattered) begin
        c.x = depth_t'($urandom);
        c.y = depth_t'($urandom);
        c.z = depth_t'($urandom);
      end else begin
        c.x = cx + jitter(spread);
        c.y = cy + jitter(spread);
        c.z = cz + jitter(spread);
      end
      c.clear = ($urandom_range(15) == 0);
      send_corner(c, 1'b0, '0);
    end
  endtask

  // ------------------------------------------------------------------------
  // result side
  // ------------------------------------------------------------------------

  // ready changes at the falling edge, zero stall odds keep it high
  always @(negedge clk) begin
    result_ch.ready = rst ? 1'b0 : ($urandom_range(99) >= result_stall_pct);
  end

  // every accepted result word against the oldest prediction
  always @(posedge clk) begin : result_check
    box_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (box_verdicts.size() == 0) begin
        $error("result word with no box outstanding");
        mismatches++;
      end else begin
        want = box_verdicts.pop_front();
        if (result_ch.visible !== want.visible) begin
          $error("visible: expected %0d, got %0d", want.visible, result_ch.visible);
          mismatches++;
        end
        if (result_ch.near_z !== want.near_z) begin
          $error("near_z: expected %0d, got %0d", want.near_z, $signed(result_ch.near_z));
          mismatches++;
        end
        if (result_ch.far_z !== want.far_z) begin
          $error("far_z: expected %0d, got %0d", want.far_z, $signed(result_ch.far_z));
          mismatches++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // run
  // ------------------------------------------------------------------------

  initial begin : run
    corner_t     c;
    box_result_t typed_res;
    clk = 1'b0;
    rst = 1'b1;
    mismatches = 0;
    corner_ch.valid        = 1'b0;
    corner_ch.corner_x     = '0;
    corner_ch.corner_y     = '0;
    corner_ch.corner_z     = '0;
    corner_ch.clear_bounds = 1'b0;
    result_ch.ready        = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = REG_ACTIVE_PLANES;
    cfg_ch.data            = '0;
    reset_model();
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // directed part: sender often idle, receiver mostly stalled
    send_idle_pct    = 33;
    result_stall_pct = 87;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (i == CULL_ROW) begin
        corner_ch.valid = 1'b0;
        drain();
        write_reg(REG_ACTIVE_PLANES, CFG_DATA_W'(ALL_PLANES_SATURATED));
        write_reg(REG_PLANE_ZERO, UNREACHABLE_PLANE);
        cfg_ch.valid = 1'b0;
      end
      c.x     = DIRECTED_TABLE[i].x;
      c.y     = DIRECTED_TABLE[i].y;
      c.z     = DIRECTED_TABLE[i].z;
      c.clear = DIRECTED_TABLE[i].clear;
      typed_res.visible = DIRECTED_TABLE[i].visible;
      typed_res.near_z  = DIRECTED_TABLE[i].near_z;
      typed_res.far_z   = DIRECTED_TABLE[i].far_z;
      send_corner(c, DIRECTED_TABLE[i].typed, typed_res);
    end

    // random part: a fresh register set per segment, first segments pin the
    // plane count to six, zero, seven and one; idle pattern flips by thirds
    for (int s = 0; s < SEGMENTS; s++) begin
      corner_ch.valid = 1'b0;
      drain();
      if (s < SEGMENTS / 3) begin
        send_idle_pct    = 33;
        result_stall_pct = 87;
      end else if (s < 2 * SEGMENTS / 3) begin
        send_idle_pct    = 87;
        result_stall_pct = 33;
      end else begin
        send_idle_pct    = 0;
        result_stall_pct = 0;
      end
      case (s)
        0: load_planes(ACTIVE_W'(MAX_PLANES));
        1: load_planes('0);
        2: load_planes(ALL_PLANES_SATURATED);
        3: load_planes(ACTIVE_W'(1));
        default: load_planes(ACTIVE_W'($urandom_range(0, 7)));
      endcase
      for (int b = 0; b < BOXES_PER_SEGMENT; b++) send_random_box();
    end

    corner_ch.valid = 1'b0;
    drain();
    if (mismatches == 0 && box_verdicts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #(WATCHDOG_TIME);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[box_plane_cull_depth_bounds.f]
design/bpc_pkg.sv
design/bpc_intf.sv
design/bpc_cfg_regs.sv
design/bpc_plane_test.sv
design/bpc_box_fold.sv
design/box_plane_cull_depth_bounds.sv
design/bpc_checker.sv
verif/tb_box_plane_cull_depth_bounds.sv
